// ----- rtl/mns_pkg.sv -----
// Shared types, constants and entry decode helpers for the melody note sequencer.
package mns_pkg;

  localparam int IDX_W       = 8;
  localparam int ENTRY_W     = 24;
  localparam int FREQ_W      = 23;
  localparam int VOL_W       = 8;
  localparam int DELAY_W     = 16;
  localparam int ELAPSED_W   = 15;
  localparam int PITCH_W     = 5;

  localparam int TABLE_DEPTH_DEF   = 256;
  localparam int DUR_UNIT_MS       = 100;
  localparam int CENTI_PER_HZ      = 100;
  localparam int COMP_DUR_BASE_MS  = 32;

  localparam logic [DELAY_W-1:0] START_DELAY_RST = 16'd100;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_PLAY = 2'd1,
    OP_LOAD = 2'd2,
    OP_STOP = 2'd3
  } mns_op_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [IDX_W-1:0]   entry_index;
    logic [ENTRY_W-1:0] entry_word;
    logic               sound_format;
    logic [VOL_W-1:0]   volume;
    logic               repeat_request;
  } mns_item_t;

  typedef struct packed {
    logic              tone_start;
    logic [FREQ_W-1:0] tone_frequency;
    logic [VOL_W-1:0]  tone_volume;
    logic              tone_stop;
    logic              busy_res;
    logic              mute;
  } mns_res_t;

  // Position counter width: wide enough for the table depth and for an
  // 8-bit start entry plus the two look-ahead slots.
  function automatic int pos_width(int depth);
    int aw;
    aw = $clog2(depth);
    return ((aw > IDX_W) ? aw : IDX_W) + 1;
  endfunction

  function automatic logic [FREQ_W-1:0] pitch_centi_hz(logic [PITCH_W-1:0] code);
    case (code)
      5'd0:    return 23'd0;
      5'd1:    return 23'd26263;
      5'd2:    return 23'd27718;
      5'd3:    return 23'd29366;
      5'd4:    return 23'd31113;
      5'd5:    return 23'd32963;
      5'd6:    return 23'd34923;
      5'd7:    return 23'd36999;
      5'd8:    return 23'd39200;
      5'd9:    return 23'd41530;
      5'd10:   return 23'd44000;
      5'd11:   return 23'd46616;
      5'd12:   return 23'd49388;
      5'd13:   return 23'd52325;
      5'd14:   return 23'd55436;
      5'd15:   return 23'd58732;
      5'd16:   return 23'd62226;
      5'd17:   return 23'd65926;
      5'd18:   return 23'd69846;
      5'd19:   return 23'd73998;
      5'd20:   return 23'd78400;
      5'd21:   return 23'd83060;
      5'd22:   return 23'd88000;
      5'd23:   return 23'd93232;
      5'd24:   return 23'd98775;
      5'd25:   return 23'd104650;
      5'd26:   return 23'd110870;
      5'd27:   return 23'd117460;
      5'd28:   return 23'd124450;
      5'd29:   return 23'd131850;
      5'd30:   return 23'd139690;
      5'd31:   return 23'd148000;
      default: return '0;
    endcase
  endfunction

  // End-of-melody marker: zero Hz (explicit) or zero byte (composite).
  function automatic logic entry_is_term(logic [ENTRY_W-1:0] e, logic expl);
    return expl ? (e[15:0] == '0) : (e[7:0] == '0);
  endfunction

  // Composite byte with pitch code zero: pass over it to the next byte.
  function automatic logic entry_skip(logic [ENTRY_W-1:0] e, logic expl);
    return !expl && (e[7:0] != '0) && (e[4:0] == '0);
  endfunction

  function automatic logic [ELAPSED_W-1:0] entry_duration(logic [ENTRY_W-1:0] e,
                                                         logic expl);
    return expl ? ELAPSED_W'(e[23:16]) * ELAPSED_W'(DUR_UNIT_MS)
                : ELAPSED_W'(COMP_DUR_BASE_MS) << e[7:5];
  endfunction

  function automatic logic [FREQ_W-1:0] entry_freq(logic [ENTRY_W-1:0] e, logic expl);
    return expl ? FREQ_W'(e[15:0]) * FREQ_W'(CENTI_PER_HZ)
                : pitch_centi_hz(e[4:0]);
  endfunction

endpackage

// ----- rtl/mns_if.sv -----
// Channel interfaces of the melody note sequencer: input items, results, configuration.
interface mns_in_if import mns_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [IDX_W-1:0]   entry_index;
  logic [ENTRY_W-1:0] entry_word;
  logic               sound_format;
  logic [VOL_W-1:0]   volume;
  logic               repeat_request;

  modport source (output valid, operation, entry_index, entry_word, sound_format,
                  volume, repeat_request, input ready);
  modport sink   (input valid, operation, entry_index, entry_word, sound_format,
                  volume, repeat_request, output ready);
endinterface

interface mns_out_if import mns_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              tone_start;
  logic [FREQ_W-1:0] tone_frequency;
  logic [VOL_W-1:0]  tone_volume;
  logic              tone_stop;
  logic              busy_res;
  logic              mute;

  modport source (output valid, tone_start, tone_frequency, tone_volume, tone_stop,
                  busy_res, mute, input ready);
  modport sink   (input valid, tone_start, tone_frequency, tone_volume, tone_stop,
                  busy_res, mute, output ready);
endinterface

interface mns_cfg_if import mns_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DELAY_W-1:0] start_delay_ms;

  modport source (output valid, start_delay_ms, input ready);
  modport sink   (input valid, start_delay_ms, output ready);
endinterface

// ----- rtl/melody_note_sequencer.sv -----
// Top level of the melody note sequencer: channel registers, config register, core.
//
// Usage:
//   in_chan  (valid/ready) takes one beat per command: a one-millisecond tick,
//            a play request, a melody table load or a stop.
//   out_chan (valid/ready) gives exactly one result beat per input beat, in
//            order: tone start with frequency (centi-Hz) and volume, tone
//            stop, running flag and mute level after that command.
//   cfg_chan (valid/ready) writes start_delay_ms; always ready. Write it only
//            while no beats are in flight.
// Path: an accepted beat is held in the input register and is then processed
//   into the output register, from which its result is offered.
// Throughput: one beat per cycle, sustained while out_chan.ready is high.
//   Each beat is decoded in one pass between the input register and the
//   output register; the two table read ports are kept pointed at the next
//   two melody words, so an advance or a first start never waits on the table.
// Reset (rst_n low, synchronous): sequencer idle, mute set, start delay 100,
//   both channel registers empty. The melody table is not cleared; load
//   every entry a melody will touch before playing it.
// Stall: while out_chan.ready is low the result holds, the input register
//   takes one more beat, and then in_chan.ready drops until the result moves.
module melody_note_sequencer import mns_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  mns_in_if.sink        in_chan,
  mns_out_if.source     out_chan,
  mns_cfg_if.sink       cfg_chan
);

  localparam int PW = pos_width(TABLE_DEPTH);

  logic               in_vld_r;
  mns_item_t          in_item_r;
  logic               out_vld_r;
  mns_res_t           out_res_r;
  logic [DELAY_W-1:0] start_delay_r;
  logic               fire;
  logic               in_take;
  mns_res_t           seq_res;

  logic               tbl_wr_en;
  logic [PW-1:0]      tbl_wr_pos;
  logic [ENTRY_W-1:0] tbl_wr_data;
  logic [PW-1:0]      tbl_rd_pos_a;
  logic [PW-1:0]      tbl_rd_pos_b;
  logic [ENTRY_W-1:0] tbl_rd_data_a;
  logic [ENTRY_W-1:0] tbl_rd_data_b;

  // Process the held beat when the output register is free or draining.
  assign fire    = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || fire;
  assign in_take = in_chan.valid && in_chan.ready;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      start_delay_r <= START_DELAY_RST;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_chan.valid) begin
        start_delay_r <= cfg_chan.start_delay_ms;
      end
    end
  end

  // Payload registers: capture on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.operation      <= in_chan.operation;
      in_item_r.entry_index    <= in_chan.entry_index;
      in_item_r.entry_word     <= in_chan.entry_word;
      in_item_r.sound_format   <= in_chan.sound_format;
      in_item_r.volume         <= in_chan.volume;
      in_item_r.repeat_request <= in_chan.repeat_request;
    end
    if (fire) begin
      out_res_r <= seq_res;
    end
  end

  mns_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk       (clk),
    .wr_en     (tbl_wr_en),
    .wr_pos    (tbl_wr_pos),
    .wr_data   (tbl_wr_data),
    .rd_pos_a  (tbl_rd_pos_a),
    .rd_pos_b  (tbl_rd_pos_b),
    .rd_data_a (tbl_rd_data_a),
    .rd_data_b (tbl_rd_data_b)
  );

  mns_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (in_item_r),
    .start_delay (start_delay_r),
    .rd_data_a   (tbl_rd_data_a),
    .rd_data_b   (tbl_rd_data_b),
    .wr_en       (tbl_wr_en),
    .wr_pos      (tbl_wr_pos),
    .wr_data     (tbl_wr_data),
    .rd_pos_a    (tbl_rd_pos_a),
    .rd_pos_b    (tbl_rd_pos_b),
    .res         (seq_res)
  );

  assign out_chan.valid          = out_vld_r;
  assign out_chan.tone_start     = out_res_r.tone_start;
  assign out_chan.tone_frequency = out_res_r.tone_frequency;
  assign out_chan.tone_volume    = out_res_r.tone_volume;
  assign out_chan.tone_stop      = out_res_r.tone_stop;
  assign out_chan.busy_res       = out_res_r.busy_res;
  assign out_chan.mute           = out_res_r.mute;

endmodule

// ----- rtl/mns_table.sv -----
// Melody table: one write port, two registered read ports with write bypass.
module mns_table import mns_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [pos_width(TABLE_DEPTH)-1:0]    wr_pos,
  input  logic [ENTRY_W-1:0]                   wr_data,
  input  logic [pos_width(TABLE_DEPTH)-1:0]    rd_pos_a,
  input  logic [pos_width(TABLE_DEPTH)-1:0]    rd_pos_b,
  output logic [ENTRY_W-1:0]                   rd_data_a,
  output logic [ENTRY_W-1:0]                   rd_data_b
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = pos_width(TABLE_DEPTH);

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_a_r;
  logic [ENTRY_W-1:0] rd_b_r;
  logic               a_in_range;
  logic               b_in_range;

  assign a_in_range = rd_pos_a < PW'(TABLE_DEPTH);
  assign b_in_range = rd_pos_b < PW'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_pos[AW-1:0]] <= wr_data;
    end
  end

  // Positions past the table read as a terminator word.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_pos == rd_pos_a)) begin
      rd_a_r <= wr_data;
    end else if (a_in_range) begin
      rd_a_r <= mem[rd_pos_a[AW-1:0]];
    end else begin
      rd_a_r <= '0;
    end
    if (wr_en && (wr_pos == rd_pos_b)) begin
      rd_b_r <= wr_data;
    end else if (b_in_range) begin
      rd_b_r <= mem[rd_pos_b[AW-1:0]];
    end else begin
      rd_b_r <= '0;
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ----- rtl/mns_seq.sv -----
// Sequencer state and single-pass next-state / result logic.
module mns_seq import mns_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fire,
  input  mns_item_t                            item,
  input  logic [DELAY_W-1:0]                   start_delay,
  input  logic [ENTRY_W-1:0]                   rd_data_a,
  input  logic [ENTRY_W-1:0]                   rd_data_b,
  output logic                                 wr_en,
  output logic [pos_width(TABLE_DEPTH)-1:0]    wr_pos,
  output logic [ENTRY_W-1:0]                   wr_data,
  output logic [pos_width(TABLE_DEPTH)-1:0]    rd_pos_a,
  output logic [pos_width(TABLE_DEPTH)-1:0]    rd_pos_b,
  output mns_res_t                             res
);

  localparam int PW = pos_width(TABLE_DEPTH);

  logic                 running_r,  running_nxt;
  logic                 pending_r,  pending_nxt;
  logic [DELAY_W-1:0]   delay_r,    delay_nxt;
  logic [IDX_W-1:0]     first_r,    first_nxt;
  logic                 fmt_r,      fmt_nxt;
  logic [VOL_W-1:0]     vol_r,      vol_nxt;
  logic [PW-1:0]        pos_r,      pos_nxt;
  logic [ELAPSED_W-1:0] elapsed_r,  elapsed_nxt;
  logic                 mute_r,     mute_nxt;
  // Cached words: current note, and the first two words of the melody.
  logic [ENTRY_W-1:0]   cur_w_r,    cur_w_nxt;
  logic [ENTRY_W-1:0]   head0_w_r,  head0_w_nxt;
  logic [ENTRY_W-1:0]   head1_w_r,  head1_w_nxt;

  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [DELAY_W-1:0]   delay_dec;
  logic [PW-1:0]        next_pos;
  logic [PW-1:0]        first_pos;
  logic                 load_ok;
  logic                 do_start;
  logic                 use_head;
  logic                 do_stop;
  logic [ENTRY_W-1:0]   pair_a;
  logic [ENTRY_W-1:0]   pair_b;
  logic [PW-1:0]        base_pos;
  logic                 skip;
  logic [ENTRY_W-1:0]   note_w;
  logic [FREQ_W-1:0]    note_freq;

  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign delay_dec   = (delay_r != '0) ? delay_r - 1'b1 : delay_r;
  assign next_pos    = pos_r + 1'b1;
  assign first_pos   = PW'(first_r);
  assign load_ok     = PW'(item.entry_index) < PW'(TABLE_DEPTH);

  always_comb begin
    running_nxt = running_r;
    pending_nxt = pending_r;
    delay_nxt   = delay_r;
    first_nxt   = first_r;
    fmt_nxt     = fmt_r;
    vol_nxt     = vol_r;
    pos_nxt     = pos_r;
    elapsed_nxt = elapsed_r;
    mute_nxt    = mute_r;
    cur_w_nxt   = cur_w_r;
    head0_w_nxt = head0_w_r;
    head1_w_nxt = head1_w_r;
    do_start    = 1'b0;
    use_head    = 1'b0;
    do_stop     = 1'b0;
    wr_en       = 1'b0;

    if (fire) begin
      case (mns_op_t'(item.operation))
        OP_TICK: begin
          if (pending_r) begin
            delay_nxt = delay_dec;
            if (delay_dec == '0) begin
              pending_nxt = 1'b0;
              do_start    = 1'b1;
            end
          end else if (running_r) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= entry_duration(cur_w_r, fmt_r)) begin
              if (entry_is_term(cur_w_r, fmt_r) || (next_pos >= PW'(TABLE_DEPTH)) ||
                  entry_is_term(rd_data_a, fmt_r)) begin
                running_nxt = 1'b0;
                do_stop     = 1'b1;
                mute_nxt    = 1'b1;
                if (item.repeat_request) begin
                  do_start = 1'b1;
                  use_head = 1'b1;
                end
              end else begin
                do_start = 1'b1;
              end
            end
          end
        end
        OP_PLAY: begin
          if (!running_r) begin
            running_nxt = 1'b1;
            pending_nxt = 1'b1;
            delay_nxt   = start_delay;
            first_nxt   = item.entry_index;
            fmt_nxt     = item.sound_format;
            vol_nxt     = item.volume;
            mute_nxt    = 1'b0;
          end
        end
        OP_LOAD: begin
          if (load_ok) begin
            wr_en = 1'b1;
            // Keep cached words coherent with the table.
            if (PW'(item.entry_index) == first_pos)        head0_w_nxt = item.entry_word;
            if (PW'(item.entry_index) == first_pos + 1'b1) head1_w_nxt = item.entry_word;
            if (PW'(item.entry_index) == pos_r)            cur_w_nxt   = item.entry_word;
          end
        end
        OP_STOP: begin
          running_nxt = 1'b0;
          pending_nxt = 1'b0;
          do_stop     = 1'b1;
          mute_nxt    = 1'b1;
        end
        default: ;
      endcase
    end

    // Word pair for the note that starts: restart uses the cached head words,
    // a first start or an advance uses the look-ahead read ports.
    pair_a   = use_head ? head0_w_r : rd_data_a;
    pair_b   = use_head ? head1_w_r : rd_data_b;
    base_pos = (use_head || pending_r) ? first_pos : next_pos;
    skip     = entry_skip(pair_a, fmt_r);
    note_w   = skip ? pair_b : pair_a;
    note_freq = entry_freq(note_w, fmt_r);

    if (do_start) begin
      running_nxt = 1'b1;
      pos_nxt     = base_pos + PW'(skip);
      cur_w_nxt   = note_w;
      elapsed_nxt = '0;
      if (pending_r) begin
        head0_w_nxt = rd_data_a;
        head1_w_nxt = rd_data_b;
      end
    end
  end

  // Look-ahead: while a start is pending read the first two words,
  // otherwise the two words after the current note.
  assign rd_pos_a = pending_nxt ? PW'(first_nxt) : pos_nxt + 1'b1;
  assign rd_pos_b = rd_pos_a + 1'b1;
  assign wr_pos   = PW'(item.entry_index);
  assign wr_data  = item.entry_word;

  assign res.tone_start     = do_start;
  assign res.tone_frequency = do_start ? note_freq : '0;
  assign res.tone_volume    = do_start ? vol_r : '0;
  assign res.tone_stop      = do_stop;
  assign res.busy_res       = running_nxt;
  assign res.mute           = mute_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      pending_r <= 1'b0;
      delay_r   <= '0;
      first_r   <= '0;
      fmt_r     <= 1'b0;
      vol_r     <= '0;
      pos_r     <= '0;
      elapsed_r <= '0;
      mute_r    <= 1'b1;
    end else begin
      running_r <= running_nxt;
      pending_r <= pending_nxt;
      delay_r   <= delay_nxt;
      first_r   <= first_nxt;
      fmt_r     <= fmt_nxt;
      vol_r     <= vol_nxt;
      pos_r     <= pos_nxt;
      elapsed_r <= elapsed_nxt;
      mute_r    <= mute_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_w_r   <= cur_w_nxt;
    head0_w_r <= head0_w_nxt;
    head1_w_r <= head1_w_nxt;
  end

  a_pending_running: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> running_r)
    else $error("start pending while sequencer not running");

  a_idle_muted: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> mute_r)
    else $error("idle sequencer left unmuted");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.operation == OP_STOP) |=> !running_r && !pending_r)
    else $error("stop did not clear running state");

  a_start_state: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.tone_start |=> running_r && !pending_r && (elapsed_r == '0))
    else $error("tone start left inconsistent note state");

endmodule

// ----- dv/melody_note_sequencer_checker.sv -----
// Checker for the melody note sequencer: watches all channels, predicts each result beat, compares.
`timescale 1ns / 100ps
module melody_note_sequencer_checker import mns_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mns_in_if    in_mon,
  mns_out_if   out_mon,
  mns_cfg_if   cfg_mon,
  output int   mismatches,
  output int   results_owed
);

  localparam int NOTE_CENTI_HZ [0:31] = '{
    0, 26263, 27718, 29366, 31113, 32963, 34923, 36999,
    39200, 41530, 44000, 46616, 49388, 52325, 55436, 58732,
    62226, 65926, 69846, 73998, 78400, 83060, 88000, 93232,
    98775, 104650, 110870, 117460, 124450, 131850, 139690, 148000
  };

  logic [DELAY_W-1:0] delay_setting;
  logic               playing;
  logic               awaiting_start;
  logic [DELAY_W-1:0] countdown;
  logic [IDX_W-1:0]   origin;
  logic               explicit_fmt;
  logic [VOL_W-1:0]   level;
  int                 cursor;
  int                 held_ms;
  logic               muted;
  logic [ENTRY_W-1:0] melody [TABLE_DEPTH_DEF];
  mns_res_t           owed_q [$];
  mns_res_t           want;
  mns_item_t          beat;

  initial mismatches = 0;

  task automatic flag_mismatch(input string field, input int got, input int predicted);
    mismatches++;
    $display("%0t: mismatch on %s: got %0d, predicted %0d", $time, field, got, predicted);
  endtask

  function automatic logic [ENTRY_W-1:0] word_at(input int addr);
    return (addr >= TABLE_DEPTH_DEF) ? '0 : melody[addr[IDX_W-1:0]];
  endfunction

  function automatic logic at_end(input int addr);
    logic [ENTRY_W-1:0] e;
    e = word_at(addr);
    return explicit_fmt ? (e[15:0] == '0) : (e[7:0] == '0);
  endfunction

  // Pitch of the note under the cursor; a composite rest byte moves the cursor on by one.
  function automatic int cursor_centi_hz();
    logic [ENTRY_W-1:0] e;
    logic [7:0]         b;
    e = word_at(cursor);
    if (explicit_fmt)
      return int'(e[15:0]) * 100;
    b = e[7:0];
    if (b != '0 && b[4:0] == '0) begin
      cursor++;
      e = word_at(cursor);
      b = e[7:0];
    end
    return NOTE_CENTI_HZ[b[4:0]];
  endfunction

  function automatic int cursor_ms();
    logic [ENTRY_W-1:0] e;
    e = word_at(cursor);
    return explicit_fmt ? int'(e[23:16]) * 100 : (32 << e[7:5]);
  endfunction

  function automatic int restart();
    cursor  = int'(origin);
    held_ms = 0;
    playing = 1'b1;
    return cursor_centi_hz();
  endfunction

  function automatic mns_res_t apply_beat(input mns_item_t b);
    mns_res_t r;
    logic     go;
    logic     halt;
    logic     here_end;
    int       hz;
    int       nxt;
    go   = 1'b0;
    halt = 1'b0;
    hz   = 0;
    case (b.operation)
      OP_TICK: begin
        if (awaiting_start) begin
          if (countdown != '0) countdown--;
          if (countdown == '0) begin
            awaiting_start = 1'b0;
            hz = restart();
            go = 1'b1;
          end
        end else if (playing) begin
          if (held_ms < 32767) held_ms++;
          if (held_ms >= cursor_ms()) begin
            here_end = at_end(cursor);
            nxt = cursor + 1;
            if (here_end || nxt >= TABLE_DEPTH_DEF || at_end(nxt)) begin
              playing = 1'b0;
              halt    = 1'b1;
              muted   = 1'b1;
              if (b.repeat_request) begin
                hz = restart();
                go = 1'b1;
              end
            end else begin
              cursor  = nxt;
              hz      = cursor_centi_hz();
              held_ms = 0;
              go      = 1'b1;
            end
          end
        end
      end
      OP_PLAY: begin
        if (!playing) begin
          playing        = 1'b1;
          awaiting_start = 1'b1;
          countdown      = delay_setting;
          origin         = b.entry_index;
          explicit_fmt   = b.sound_format;
          level          = b.volume;
          muted          = 1'b0;
        end
      end
      OP_LOAD: melody[b.entry_index] = b.entry_word;
      OP_STOP: begin
        playing        = 1'b0;
        awaiting_start = 1'b0;
        halt           = 1'b1;
        muted          = 1'b1;
      end
      default: ;
    endcase
    r.tone_start     = go;
    r.tone_frequency = go ? FREQ_W'(hz) : '0;
    r.tone_volume    = go ? level : '0;
    r.tone_stop      = halt;
    r.busy_res       = playing;
    r.mute           = muted;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      delay_setting  = START_DELAY_RST;
      playing        = 1'b0;
      awaiting_start = 1'b0;
      countdown      = '0;
      origin         = '0;
      explicit_fmt   = 1'b0;
      level          = '0;
      cursor         = 0;
      held_ms        = 0;
      muted          = 1'b1;
      owed_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready)
        delay_setting = cfg_mon.start_delay_ms;
      if (out_mon.valid && out_mon.ready) begin
        if (owed_q.size() == 0) begin
          flag_mismatch("result with none owed", 1, 0);
        end else begin
          want = owed_q.pop_front();
          if (out_mon.tone_start !== want.tone_start)
            flag_mismatch("tone_start", int'(out_mon.tone_start), int'(want.tone_start));
          if (out_mon.tone_frequency !== want.tone_frequency)
            flag_mismatch("tone_frequency", int'(out_mon.tone_frequency),
                          int'(want.tone_frequency));
          if (out_mon.tone_volume !== want.tone_volume)
            flag_mismatch("tone_volume", int'(out_mon.tone_volume), int'(want.tone_volume));
          if (out_mon.tone_stop !== want.tone_stop)
            flag_mismatch("tone_stop", int'(out_mon.tone_stop), int'(want.tone_stop));
          if (out_mon.busy_res !== want.busy_res)
            flag_mismatch("busy_res", int'(out_mon.busy_res), int'(want.busy_res));
          if (out_mon.mute !== want.mute)
            flag_mismatch("mute", int'(out_mon.mute), int'(want.mute));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        beat.operation      = in_mon.operation;
        beat.entry_index    = in_mon.entry_index;
        beat.entry_word     = in_mon.entry_word;
        beat.sound_format   = in_mon.sound_format;
        beat.volume         = in_mon.volume;
        beat.repeat_request = in_mon.repeat_request;
        owed_q.push_back(apply_beat(beat));
      end
    end
    results_owed = owed_q.size();
  end

endmodule

// ----- dv/melody_note_sequencer_tb.sv -----
// Testbench top for the melody note sequencer: clock, reset, stimulus, back-pressure, verdict.
`timescale 1ns / 100ps
module melody_note_sequencer_tb;
  import mns_pkg::*;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  mns_in_if  in_chan ();
  mns_out_if out_chan ();
  mns_cfg_if cfg_chan ();

  int   mismatches;
  int   results_owed;
  int   beats_sent = 0;
  int   delay_now  = int'(START_DELAY_RST);
  logic steady     = 1'b0;  // suppress random idling on both sides
  logic choke_now  = 1'b0;  // ask the receiver for one long hold-off

  melody_note_sequencer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  melody_note_sequencer_checker watch (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .cfg_mon      (cfg_chan),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  always #10 clk = ~clk;

  // Hard stop in case a handshake never completes.
  initial begin
    #4_000_000;
    $display("melody_note_sequencer_tb: done, errors");
    $finish;
  end

  // Result side: take beats at random, except during a steady stretch or a
  // requested hold-off. The hold-off keeps ready low long enough for the
  // block's two registers to fill and push back on the input channel.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (choke_now) begin
        choke_now = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (60) @(negedge clk);
      end
      out_chan.ready <= steady || ($urandom_range(99) >= 27);
    end
  end

  // Offer one input beat and hold it until accepted. Returns at the falling
  // edge after the accepting edge, so the caller can put up the next beat
  // (or drop valid) in the same step without a second assignment.
  task automatic send_beat(input mns_op_t op, input logic [IDX_W-1:0] idx,
                           input logic [ENTRY_W-1:0] word, input logic fmt,
                           input logic [VOL_W-1:0] vol, input logic rep);
    while (!steady && $urandom_range(99) < 27) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.operation      <= op;
    in_chan.entry_index    <= idx;
    in_chan.entry_word     <= word;
    in_chan.sound_format   <= fmt;
    in_chan.volume         <= vol;
    in_chan.repeat_request <= rep;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    beats_sent++;
  endtask

  // Write start_delay_ms with nothing in flight: drop valid, drain every
  // owed result, let the pipeline settle, then write.
  task automatic write_delay(input logic [DELAY_W-1:0] ms);
    in_chan.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_chan.valid          <= 1'b1;
    cfg_chan.start_delay_ms <= ms;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
    delay_now = int'(ms);
  endtask

  // One melody: load a short well-formed tune at a random start entry,
  // terminate it, pad two words past the end, play it and tick it through.
  // Ticks carry an occasional repeat request; a little noise (loads, plays
  // while running, stops) is mixed in.
  task automatic run_tune();
    int                 first;
    int                 notes;
    int                 k;
    int                 code;
    int                 span_ms;
    int                 budget;
    logic               fmt;
    logic [7:0]         cbyte;
    logic [ENTRY_W-1:0] w;
    fmt     = 1'($urandom);
    first   = $urandom_range(TABLE_DEPTH_DEF - 1);
    notes   = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
    span_ms = 32;
    for (k = 0; k < notes + 3 && first + k < TABLE_DEPTH_DEF; k++) begin
      if (k < notes && fmt) begin
        // Mostly zero-length notes so explicit melodies step every tick.
        code = ($urandom_range(3) == 0) ? 1 : 0;
        w = {8'(code), 16'($urandom_range(65535, 1))};
        span_ms += code * 100 + 2;
      end else if (k < notes) begin
        // Pitch code zero is a skipped rest byte, or a terminator with duration code zero.
        code  = ($urandom_range(7) == 0) ? $urandom_range(3, 2) : $urandom_range(1);
        cbyte = {3'(code), ($urandom_range(7) == 0) ? 5'd0 : 5'($urandom_range(31, 1))};
        w = {16'($urandom), cbyte};
        span_ms += (32 << code) + 2;
      end else if (k == notes) begin
        w = {8'($urandom_range(1)), 16'h0000};
      end else begin
        w = 24'($urandom);
      end
      send_beat(OP_LOAD, IDX_W'(first + k), w, 1'($urandom), 8'($urandom), 1'($urandom));
    end
    send_beat(OP_PLAY, IDX_W'(first), 24'($urandom), fmt, 8'($urandom), 1'($urandom));
    budget = ((delay_now > 150) ? 40 : delay_now) + span_ms + $urandom_range(12);
    for (k = 0; k < budget; k++) begin
      case ($urandom_range(199))
        0, 1:    send_beat(OP_LOAD, 8'($urandom), 24'($urandom), 1'($urandom),
                           8'($urandom), 1'($urandom));
        2:       send_beat(OP_PLAY, 8'($urandom), 24'($urandom), 1'($urandom),
                           8'($urandom), 1'($urandom));
        3:       send_beat(OP_STOP, 8'($urandom), 24'($urandom), 1'($urandom),
                           8'($urandom), 1'($urandom));
        default: send_beat(OP_TICK, 8'($urandom), 24'($urandom), 1'($urandom),
                           8'($urandom), $urandom_range(15) == 0);
      endcase
    end
    // A long start delay never expires here; cancel it so later tunes run.
    if (delay_now > 150 || $urandom_range(9) < 7)
      send_beat(OP_STOP, 8'($urandom), 24'($urandom), 1'($urandom), 8'($urandom), 1'b0);
  endtask

  initial begin
    int k;
    int tune_no;
    in_chan.valid          = 1'b0;
    in_chan.operation      = OP_TICK;
    in_chan.entry_index    = '0;
    in_chan.entry_word     = '0;
    in_chan.sound_format   = 1'b0;
    in_chan.volume         = '0;
    in_chan.repeat_request = 1'b0;
    cfg_chan.valid          = 1'b0;
    cfg_chan.start_delay_ms = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill the whole table with terminators so no play can ever read an
    // entry that was never loaded. Durations are 0 or 100 ms explicit, 32 ms composite.
    for (k = 0; k < TABLE_DEPTH_DEF; k++)
      send_beat(OP_LOAD, IDX_W'(k), {8'($urandom_range(1)), 16'h0000}, 1'($urandom),
                8'($urandom), 1'($urandom));

    // First tune runs with the start delay left at its reset value.
    run_tune();

    // Directed cases, start delay zero so the first tick starts the note.
    write_delay(16'd0);
    send_beat(OP_STOP, 8'd0, 24'd0, 1'b0, 8'd0, 1'b0);
    // Highest explicit frequency with zero duration, then end on terminator.
    send_beat(OP_LOAD, 8'd10, 24'h00FFFF, 1'b0, 8'd0, 1'b0);
    send_beat(OP_LOAD, 8'd11, 24'h000000, 1'b0, 8'd0, 1'b0);
    send_beat(OP_PLAY, 8'd10, 24'd0, 1'b1, 8'hFF, 1'b0);
    // Play while a start is pending: drop it.
    send_beat(OP_PLAY, 8'd0, 24'hFFFFFF, 1'b0, 8'h00, 1'b1);
    send_beat(OP_TICK, 8'd0, 24'd0, 1'b0, 8'd0, 1'b0);
    send_beat(OP_TICK, 8'd0, 24'd0, 1'b0, 8'd0, 1'b0);
    // Last table entry, all-ones word: max frequency and longest duration.
    send_beat(OP_LOAD, 8'd255, 24'hFFFFFF, 1'b1, 8'hFF, 1'b1);
    send_beat(OP_PLAY, 8'd255, 24'd0, 1'b1, 8'h5A, 1'b0);
    send_beat(OP_TICK, 8'hFF, 24'hFFFFFF, 1'b1, 8'hFF, 1'b0);
    send_beat(OP_TICK, 8'd0, 24'd0, 1'b0, 8'd0, 1'b0);
    send_beat(OP_STOP, 8'd0, 24'd0, 1'b0, 8'd0, 1'b0);
    // Composite rest byte followed by the highest pitch code.
    send_beat(OP_LOAD, 8'd20, 24'h000020, 1'b0, 8'd0, 1'b0);
    send_beat(OP_LOAD, 8'd21, 24'h00001F, 1'b0, 8'd0, 1'b0);
    send_beat(OP_PLAY, 8'd20, 24'd0, 1'b0, 8'd1, 1'b0);
    send_beat(OP_TICK, 8'd0, 24'd0, 1'b0, 8'd0, 1'b0);
    send_beat(OP_STOP, 8'd0, 24'd0, 1'b0, 8'd0, 1'b0);
    // Two rest bytes in a row: the tone starts at zero frequency.
    send_beat(OP_LOAD, 8'd30, 24'h000040, 1'b0, 8'd0, 1'b0);
    send_beat(OP_LOAD, 8'd31, 24'h000060, 1'b0, 8'd0, 1'b0);
    send_beat(OP_PLAY, 8'd30, 24'd0, 1'b0, 8'd77, 1'b0);
    send_beat(OP_TICK, 8'd0, 24'd0, 1'b0, 8'd0, 1'b0);
    send_beat(OP_STOP, 8'd0, 24'd0, 1'b0, 8'd0, 1'b0);
    // Empty explicit melody, repeat requested on the ending tick: restart
    // with mute still set, then stop and tick while idle.
    send_beat(OP_LOAD, 8'd40, 24'h000000, 1'b0, 8'd0, 1'b0);
    send_beat(OP_PLAY, 8'd40, 24'd0, 1'b1, 8'd9, 1'b0);
    send_beat(OP_TICK, 8'd0, 24'd0, 1'b0, 8'd0, 1'b0);
    send_beat(OP_TICK, 8'd0, 24'd0, 1'b0, 8'd0, 1'b1);
    send_beat(OP_STOP, 8'd0, 24'd0, 1'b0, 8'd0, 1'b0);
    send_beat(OP_TICK, 8'd0, 24'd0, 1'b0, 8'd0, 1'b1);

    // Random tunes until the beat total is reached, at least four of them.
    // Change the start delay every other tune, the extremes early on; one
    // steady stretch over two tunes and two long result hold-offs.
    tune_no = 0;
    while (beats_sent < 1150 || tune_no < 4) begin
      if (tune_no % 2 == 0) begin
        case (tune_no / 2)
          0:       write_delay(16'd1);
          1:       write_delay(16'hFFFF);
          2:       write_delay(16'd0);
          3:       write_delay(16'd5);
          4:       write_delay(16'd2);
          5:       write_delay(16'd17);
          default: write_delay(DELAY_W'($urandom_range(20)));
        endcase
      end
      steady = (tune_no == 2 || tune_no == 3);
      if (tune_no == 1 || tune_no == 3)
        choke_now = 1'b1;
      run_tune();
      tune_no++;
    end
    steady = 1'b0;

    // Drain, let the pipeline settle, give the verdict.
    in_chan.valid <= 1'b0;
    for (k = 0; k < 5000 && results_owed != 0; k++) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0 && results_owed == 0)
      $display("melody_note_sequencer_tb: done, clean");
    else
      $display("melody_note_sequencer_tb: done, errors");
    $finish;
  end

endmodule
